@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on aclk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tcw_pkg.sv @@
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types and character codes of the text terminal character writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

    localparam int CHAR_W = 7;

    typedef logic [CHAR_W-1:0] char_t;

    // Cell store write port controls
    typedef struct packed {
        logic  en;
        char_t data;
    } tcw_wr_t;

    // Character codes
    localparam logic [7:0] CH_BS          = 8'd8;
    localparam logic [7:0] CH_LF          = 8'd10;
    localparam logic [7:0] CH_CR          = 8'd13;
    localparam logic [7:0] CH_PRINT_FIRST = 8'd32;
    localparam logic [7:0] CH_DEL         = 8'd127;
    localparam logic [7:0] CH_PRINT_LAST  = CH_DEL - 8'd1;
    localparam char_t      CHAR_SPACE     = 7'd32;

    // Operations
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // Control states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_COPY  = 5'b01000,
        ST_FILL  = 5'b10000
    } state_t;

endpackage

@@ design/tcw_cell_ram.sv @@
// ---------------------------------------------------------------------------
// tcw_cell_ram
// Character cell store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int ADDR_W = 13
) (
    input  logic                 aclk,
    input  tcw_pkg::tcw_wr_t     wr,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output tcw_pkg::char_t       rd_data
);
    import tcw_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    char_t mem [DEPTH];
    char_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
    end

    // Read port, data held between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/text_terminal_char_writer_unit.sv @@
// ---------------------------------------------------------------------------
// text_terminal_char_writer_unit
// Dumb terminal character writer: cursor handling, wrap and scroll-up over
// a character cell store.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one beat per stream byte or cell read (valid/
//   ready). The m_ channel returns exactly one beat per input beat: cursor
//   after the step, the read character and a scroll flag. cfg_wr_en writes
//   screen_columns (index 0) or screen_rows (index 1).
// Sequence:
//   An ordinary byte or a read is accepted (cell read issued), then
//   executed (cell write or read data taken). A printable byte that
//   scrolls walks the active area through the cell store's read and write
//   ports, one cell a cycle: each row is copied up from the row below,
//   then the bottom row is filled with spaces, the fill alone on a one-row screen.
// Reset:
//   The cursor goes to 0,0 and the registers to 80 columns by 24 rows.
//   A clearing pass then writes a space into every cell, one a cycle,
//   2**(clog2(MAX_ROWS) + clog2(MAX_COLUMNS)) cells (8192 by default);
//   s_ready stays low until it is done.
// Stalls:
//   The result sits in an output register; while m_ready is low the next
//   item may be accepted but is not executed until the register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_terminal_char_writer_unit #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_wdata,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [7:0]           s_stream_byte,
    input  logic [5:0]           s_read_row,
    input  logic [6:0]           s_read_column,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_cursor_column,
    output logic [5:0]           m_cursor_row,
    output tcw_pkg::char_t       m_read_char,
    output logic                 m_scrolled
);
    import tcw_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int AW = RW + CW;

    function automatic logic [AW-1:0] cell_addr(input logic [7:0] r, input logic [7:0] c);
        cell_addr = {r[RW-1:0], c[CW-1:0]};
    endfunction

    // Registers
    state_t        state_reg, state_next;
    logic [7:0]    cfg_cols_reg;
    logic [6:0]    cfg_rows_reg;
    logic [7:0]    col_reg, col_next;
    logic [5:0]    row_reg, row_next;
    logic          flag_reg, flag_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [7:0]    sc_row_reg, sc_row_next;
    logic [7:0]    sc_col_reg, sc_col_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          op_reg;
    logic [7:0]    byte_reg;
    logic [5:0]    rrow_reg;
    logic [6:0]    rcol_reg;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    out_col_reg;
    logic [5:0]    out_row_reg;
    char_t         out_char_reg, out_char_next;
    logic          out_scr_reg, out_scr_next;

    // RAM interface
    tcw_wr_t       wr;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    char_t         rd_data;

    // Misc
    logic [7:0]    cols8, rows8;
    logic          slot_free;
    logic          res_load;
    logic          wrap;
    logic [7:0]    pcol, prow;
    logic          in_accept;
    logic          in_scroll;

    tcw_cell_ram #(.ADDR_W(AW)) u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Active area, out-of-range counts clamped
    always_comb begin
        if (cfg_cols_reg == 8'd0) begin
            cols8 = 8'd1;
        end else if ({1'b0, cfg_cols_reg} > 9'(MAX_COLUMNS)) begin
            cols8 = 8'(MAX_COLUMNS);
        end else begin
            cols8 = cfg_cols_reg;
        end
        if (cfg_rows_reg == 7'd0) begin
            rows8 = 8'd1;
        end else if ({1'b0, cfg_rows_reg} > 8'(MAX_ROWS)) begin
            rows8 = 8'(MAX_ROWS);
        end else begin
            rows8 = {1'b0, cfg_rows_reg};
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign in_scroll = (state_reg == ST_COPY) || (state_reg == ST_FILL);

    // Pending wrap for a printable byte
    assign wrap = (col_reg >= cols8);
    assign pcol = wrap ? 8'd0 : col_reg;
    assign prow = wrap ? ({2'b00, row_reg} + 8'd1) : {2'b00, row_reg};

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        flag_next      = flag_reg;
        clr_next       = clr_reg;
        sc_row_next    = sc_row_reg;
        sc_col_next    = sc_col_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        wr             = '{en: 1'b0, data: CHAR_SPACE};
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = cell_addr({2'b00, s_read_row}, {1'b0, s_read_column});
        res_load       = 1'b0;
        out_char_next  = '0;
        out_scr_next   = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;

        // copied cell from the previous scroll read
        if (pend_reg) begin
            wr      = '{en: 1'b1, data: rd_data};
            wr_addr = pend_addr_reg;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr      = '{en: 1'b1, data: CHAR_SPACE};
                wr_addr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    rd_en      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    if (op_reg == OP_READ) begin
                        res_load = 1'b1;
                        if (({2'b00, rrow_reg} < rows8) && ({1'b0, rcol_reg} < cols8)) begin
                            out_char_next = rd_data;
                        end else begin
                            out_char_next = CHAR_SPACE;
                        end
                    end else begin
                        case (byte_reg)
                            CH_LF: begin
                                res_load = 1'b1;
                                col_next = 8'd0;
                                if (({2'b00, row_reg} + 8'd1) >= rows8) begin
                                    row_next = 6'(rows8 - 8'd1);
                                end else begin
                                    row_next = row_reg + 6'd1;
                                end
                            end
                            CH_CR: begin
                                res_load = 1'b1;
                                col_next = 8'd0;
                            end
                            CH_BS: begin
                                res_load = 1'b1;
                                if (col_reg != 8'd0) begin
                                    col_next = col_reg - 8'd1;
                                end
                            end
                            default: begin
                                if (byte_reg inside {[CH_PRINT_FIRST:CH_PRINT_LAST]}) begin
                                    if (prow >= rows8) begin
                                        // scroll first; cursor lands on the bottom row
                                        col_next    = pcol;
                                        row_next    = 6'(rows8 - 8'd1);
                                        flag_next   = 1'b1;
                                        sc_col_next = 8'd0;
                                        if (rows8 == 8'd1) begin
                                            sc_row_next = 8'd0;
                                            state_next  = ST_FILL;
                                        end else begin
                                            sc_row_next = 8'd0;
                                            state_next  = ST_COPY;
                                        end
                                    end else begin
                                        res_load = 1'b1;
                                        wr       = '{en: 1'b1, data: byte_reg[CHAR_W-1:0]};
                                        wr_addr  = cell_addr(prow, pcol);
                                        col_next = pcol + 8'd1;
                                        row_next = prow[5:0];
                                    end
                                end else begin
                                    res_load = 1'b1;
                                end
                            end
                        endcase
                        out_scr_next = flag_reg;
                    end
                    if (res_load) begin
                        flag_next    = 1'b0;
                        m_valid_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_COPY: begin
                // read row below, write it back in the next cycle
                rd_en          = 1'b1;
                rd_addr        = cell_addr(sc_row_reg + 8'd1, sc_col_reg);
                pend_next      = 1'b1;
                pend_addr_next = cell_addr(sc_row_reg, sc_col_reg);
                if (sc_col_reg == cols8 - 8'd1) begin
                    sc_col_next = 8'd0;
                    if (sc_row_reg == rows8 - 8'd2) begin
                        sc_row_next = rows8 - 8'd1;
                        state_next  = ST_FILL;
                    end else begin
                        sc_row_next = sc_row_reg + 8'd1;
                    end
                end else begin
                    sc_col_next = sc_col_reg + 8'd1;
                end
            end
            ST_FILL: begin
                // bottom row to spaces, after the last copy has drained
                if (!pend_reg) begin
                    wr      = '{en: 1'b1, data: CHAR_SPACE};
                    wr_addr = cell_addr(sc_row_reg, sc_col_reg);
                    if (sc_col_reg == cols8 - 8'd1) begin
                        state_next = ST_EXEC;
                    end else begin
                        sc_col_next = sc_col_reg + 8'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cfg_cols_reg <= 8'd80;
            cfg_rows_reg <= 7'd24;
            col_reg      <= 8'd0;
            row_reg      <= 6'd0;
            flag_reg     <= 1'b0;
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            flag_reg    <= flag_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_COLUMNS: cfg_cols_reg <= cfg_wdata;
                    REG_ROWS:    cfg_rows_reg <= cfg_wdata[6:0];
                    default:     cfg_cols_reg <= cfg_cols_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        sc_row_reg    <= sc_row_next;
        sc_col_reg    <= sc_col_next;
        pend_addr_reg <= pend_addr_next;
        if (in_accept) begin
            op_reg   <= s_operation;
            byte_reg <= s_stream_byte;
            rrow_reg <= s_read_row;
            rcol_reg <= s_read_column;
        end
        if (res_load) begin
            out_col_reg  <= col_next;
            out_row_reg  <= row_next;
            out_char_reg <= out_char_next;
            out_scr_reg  <= out_scr_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_column = out_col_reg;
    assign m_cursor_row    = out_row_reg;
    assign m_read_char     = out_char_reg;
    assign m_scrolled      = out_scr_reg;

    // Assertions
    `ASSERT_IMPL(a_pend_in_scroll, pend_reg, in_scroll, "scroll write pending outside scroll")
    `ASSERT_NEXT(a_accept_exec, in_accept, state_reg == ST_EXEC, "accepted beat not executed")
    `ASSERT_NEXT(a_copy_pend, state_reg == ST_COPY, pend_reg, "copy read without write-back")
    `ASSERT_NEXT(a_result_held, m_valid_reg && !m_ready, m_valid_reg, "stalled result dropped")

endmodule
